// ===== hw/rtl/itoa_pkg.sv =====
// Shared widths, character codes and cell control type for the integer-to-text block.
package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W  = $clog2(VALUE_W);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/itoa_in_if.sv =====
// Input channel carrying one signed integer word.
interface itoa_in_if
    import itoa_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== hw/rtl/itoa_out_if.sv =====
// Output channel carrying one ASCII character word and its end flag.
interface itoa_out_if
    import itoa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== hw/rtl/itoa_cell.sv =====
// One BCD digit cell of the shift-and-add-3 chain.
module itoa_cell
    import itoa_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic               carry_in,
    output logic               carry_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    assign carry_out = adj[DIGIT_W-1];

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
// The accepted number passes through the conversion and load states before the first character is registered on text.
// The magnitude shifts through a row of ten BCD cells, one bit per cycle.
// Throughput: one character per cycle while text is ready; a new number is taken only after the last character.
// Reset: asynchronous, active low; returns to idle with no character pending.
module signed_int_to_decimal_ascii
    import itoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    itoa_in_if.sink     number,
    itoa_out_if.source  text
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VALUE_W-1:0]   mag_reg, mag_next;
    logic                 neg_reg, neg_next;
    logic                 sign_reg, sign_next;
    logic [DIG_IDX_W-1:0] idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic [VALUE_W-1:0]   raw;
    logic [VALUE_W-1:0]   mag_in;
    logic                 accept;
    logic                 out_free;
    cell_ctrl_t           ctrl;
    logic [NUM_DIGITS-1:0] cin;
    logic [NUM_DIGITS-1:0] cout;
    logic [DIGIT_W-1:0]   digit [NUM_DIGITS];
    logic [DIG_IDX_W-1:0] top_idx;

    assign raw    = $unsigned(number.value);
    assign mag_in = raw[VALUE_W-1] ? (~raw + 32'd1) : raw;
    assign number.ready = (state_reg == ST_IDLE);
    assign accept = number.valid && number.ready;
    assign out_free = !out_valid_reg || text.ready;

    assign ctrl.clear = accept;
    assign ctrl.shift = (state_reg == ST_CONV);

    assign cin[0] = mag_reg[VALUE_W-1];

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign cin[gi] = cout[gi-1];
            end
            itoa_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .carry_in  (cin[gi]),
                .carry_out (cout[gi]),
                .digit     (digit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digit[i] != '0)
            begin
                top_idx = DIG_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        sign_next      = sign_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next   = mag_in;
                    neg_next   = raw[VALUE_W-1];
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                idx_next   = top_idx;
                sign_next  = neg_reg;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + {2'b00, digit[idx_reg]};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sign_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sign_reg      <= sign_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last_char = last_reg;

endmodule

// ===== hw/rtl/itoa_checker.sv =====
// Port-level checks for the integer-to-text block, bound to its top level.
module itoa_checker
    import itoa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] char_code,
    input logic              last_char
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("text word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_code) && $stable(last_char))
        else $error("text word changed while stalled");

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (char_code == CHAR_MINUS)
                   || (char_code >= CHAR_ZERO && char_code <= CHAR_NINE))
        else $error("character outside minus and digits");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (char_code == CHAR_MINUS) |-> !last_char)
        else $error("minus sign flagged as final character");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second number taken during conversion");

endmodule

bind signed_int_to_decimal_ascii itoa_checker u_itoa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (number.valid),
    .in_ready  (number.ready),
    .out_valid (text.valid),
    .out_ready (text.ready),
    .char_code (text.char_code),
    .last_char (text.last_char)
);
